### hw/rtl/sacl_pkg.sv
// shared types and constants for the set-associative lru cache simulator
package sacl_pkg;

   localparam int CNT_W      = 32;
   localparam int AGE_W      = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BITS = 2'd2;

   // register reset values
   localparam logic [3:0] SET_BITS_RST   = 4'd4;
   localparam logic [3:0] WAYS_RST       = 4'd1;
   localparam logic [4:0] BLOCK_BITS_RST = 5'd4;
   localparam logic [4:0] BLOCK_BITS_MAX = 5'd16;

   // access kinds (load and the unused code behave alike)
   localparam logic [1:0] KIND_MODIFY = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] address;
   } req_type;

   typedef struct packed {
      logic             hit;
      logic             miss;
      logic             evicted;
      logic             modify_hit;
      logic [2:0]       way_used;
      logic [7:0]       set_index;
      logic [CNT_W-1:0] hits_total;
      logic [CNT_W-1:0] misses_total;
      logic [CNT_W-1:0] evictions_total;
   } rsp_type;

   typedef struct packed {
      logic clear_wr;
      logic load_req;
      logic eval;
      logic commit;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_last;
   } dp_stat_type;

endpackage

### hw/rtl/sacl_ctrl.sv
// sequencing state machine for the cache simulator
module sacl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  sacl_pkg::dp_stat_type stat,
   output sacl_pkg::ctl_cmd_type cmd
);
   import sacl_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_LOOKUP = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      commit;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   // result register must be free or draining this cycle
   assign commit    = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      cmd.clear_wr = (state_ff == ST_CLEAR);
      cmd.load_req = (state_ff == ST_IDLE) && req_valid;
      cmd.eval     = (state_ff == ST_LOOKUP);
      cmd.commit   = commit;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (commit) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      priority if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hw/rtl/sacl_dp.sv
// tag, valid and age memories, address decode, lookup and replacement datapath
module sacl_dp #(
   parameter int MAX_SET_BITS = 8,
   parameter int MAX_WAYS     = 8,
   parameter int ADDRESS_BITS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sacl_pkg::ctl_cmd_type               cmd,
   output sacl_pkg::dp_stat_type               stat,
   input  logic                                csr_we,
   input  logic [sacl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sacl_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  sacl_pkg::req_type                   req_data,
   output sacl_pkg::rsp_type                   rsp_data
);
   import sacl_pkg::*;

   localparam int NUM_SETS = 1 << MAX_SET_BITS;
   localparam int SET_W    = MAX_SET_BITS;
   localparam int TAG_W    = ADDRESS_BITS - 2;
   localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

   // configuration
   logic [3:0] set_bits_ff,   set_bits_in;
   logic [3:0] ways_ff,       ways_in;
   logic [4:0] block_bits_ff, block_bits_in;
   logic [3:0] sb;
   logic [4:0] nw;
   logic [4:0] bb;

   // memories, one row per set
   logic [MAX_WAYS-1:0]                  valid_mem [NUM_SETS];
   logic [MAX_WAYS-1:0][TAG_W-1:0]       tag_mem   [NUM_SETS];
   logic [MAX_WAYS-1:0][AGE_W-1:0]       age_mem   [NUM_SETS];
   logic [MAX_WAYS-1:0]                  rd_valid_ff;
   logic [MAX_WAYS-1:0][TAG_W-1:0]       rd_tag_ff;
   logic [MAX_WAYS-1:0][AGE_W-1:0]       rd_age_ff;

   logic [SET_W-1:0] clr_cnt_ff, clr_cnt_in;

   // decode
   logic [ADDRESS_BITS-1:0] addr_m;
   logic [ADDRESS_BITS-1:0] set_shift;
   logic [ADDRESS_BITS-1:0] tag_shift;
   logic [5:0]              tag_sh;
   logic [SET_W-1:0]        set_mask;
   logic [SET_W-1:0]        set_dec;
   logic [SET_W-1:0]        set_ff;
   logic [TAG_W-1:0]        tag_ff;
   logic                    modify_ff;

   // lookup
   logic [MAX_WAYS-1:0] in_use;
   logic [MAX_WAYS-1:0] match;
   logic [MAX_WAYS-1:0] invalid;
   logic [MAX_WAYS-1:0] oldest;
   logic [WAY_W-1:0]    hit_way;
   logic [WAY_W-1:0]    inv_way;
   logic [WAY_W-1:0]    old_way;
   logic                hit_ff;
   logic                evict_ff;
   logic [WAY_W-1:0]    way_ff;

   // update
   logic [MAX_WAYS-1:0]            new_valid;
   logic [MAX_WAYS-1:0][TAG_W-1:0] new_tag;
   logic [MAX_WAYS-1:0][AGE_W-1:0] new_age;
   logic                           wr_en;
   logic [SET_W-1:0]               wr_addr;
   logic [CNT_W-1:0]               hit_cnt_ff,   hit_cnt_in;
   logic [CNT_W-1:0]               miss_cnt_ff,  miss_cnt_in;
   logic [CNT_W-1:0]               evict_cnt_ff, evict_cnt_in;
   logic [CNT_W:0]                 hit_sum;
   logic [1:0]                     hit_inc;
   logic [63:0]                    set_wide;
   logic [31:0]                    way_wide;
   rsp_type                        rsp_ff, rsp_in;

   // configuration writes
   always_comb begin
      set_bits_in   = set_bits_ff;
      ways_in       = ways_ff;
      block_bits_in = block_bits_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SET_BITS:   set_bits_in   = csr_wdata[3:0];
            CSR_WAYS:       ways_in       = csr_wdata[3:0];
            CSR_BLOCK_BITS: block_bits_in = csr_wdata;
            default:        ;
         endcase
      end
   end

   // registers read saturated into their ranges
   always_comb begin
      priority if (set_bits_ff == 4'd0) begin
         sb = 4'd1;
      end else if (set_bits_ff > 4'(MAX_SET_BITS)) begin
         sb = 4'(MAX_SET_BITS);
      end else begin
         sb = set_bits_ff;
      end
      priority if (ways_ff == 4'd0) begin
         nw = 5'd1;
      end else if (5'(ways_ff) > 5'(MAX_WAYS)) begin
         nw = 5'(MAX_WAYS);
      end else begin
         nw = 5'(ways_ff);
      end
      priority if (block_bits_ff == 5'd0) begin
         bb = 5'd1;
      end else if (block_bits_ff > BLOCK_BITS_MAX) begin
         bb = BLOCK_BITS_MAX;
      end else begin
         bb = block_bits_ff;
      end
   end

   // address decode straight off the request beat
   always_comb begin
      addr_m    = req_data.address[ADDRESS_BITS-1:0];
      set_shift = addr_m >> bb;
      set_mask  = ~({SET_W{1'b1}} << sb);
      set_dec   = set_shift[SET_W-1:0] & set_mask;
      tag_sh    = 6'(bb) + 6'(sb);
      tag_shift = addr_m >> tag_sh;
   end

   // lookup over the ways of the set
   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         in_use[w]  = (5'(w) < nw);
         match[w]   = in_use[w] && rd_valid_ff[w] && (rd_tag_ff[w] == tag_ff);
         invalid[w] = in_use[w] && !rd_valid_ff[w];
      end
      // victim: largest age, lowest way on ties
      for (int w = 0; w < MAX_WAYS; w++) begin
         oldest[w] = in_use[w];
         for (int j = 0; j < MAX_WAYS; j++) begin
            if (j < w && in_use[j] && !(rd_age_ff[w] > rd_age_ff[j])) oldest[w] = 1'b0;
            if (j > w && in_use[j] && (rd_age_ff[w] < rd_age_ff[j])) oldest[w] = 1'b0;
         end
      end
      hit_way = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (match[w]) hit_way = WAY_W'(w);
      end
      inv_way = '0;
      old_way = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (invalid[w]) inv_way = WAY_W'(w);
         if (oldest[w])  old_way = WAY_W'(w);
      end
   end

   // new row contents
   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         new_valid[w] = rd_valid_ff[w] || (WAY_W'(w) == way_ff);
         new_tag[w]   = (WAY_W'(w) == way_ff) ? tag_ff : rd_tag_ff[w];
         if (!in_use[w]) begin
            new_age[w] = rd_age_ff[w];
         end else if (WAY_W'(w) == way_ff) begin
            new_age[w] = AGE_W'(1);
         end else if (&rd_age_ff[w]) begin
            new_age[w] = rd_age_ff[w];
         end else begin
            new_age[w] = rd_age_ff[w] + AGE_W'(1);
         end
      end
   end

   // running totals
   always_comb begin
      hit_inc = 2'(hit_ff) + 2'(modify_ff);
      hit_sum = {1'b0, hit_cnt_ff} + (CNT_W + 1)'(hit_inc);
      hit_cnt_in   = hit_sum[CNT_W] ? {CNT_W{1'b1}} : hit_sum[CNT_W-1:0];
      miss_cnt_in  = miss_cnt_ff;
      evict_cnt_in = evict_cnt_ff;
      if (!hit_ff && !(&miss_cnt_ff))  miss_cnt_in  = miss_cnt_ff + CNT_W'(1);
      if (evict_ff && !(&evict_cnt_ff)) evict_cnt_in = evict_cnt_ff + CNT_W'(1);
   end

   always_comb begin
      set_wide              = 64'(set_ff);
      way_wide              = 32'(way_ff);
      rsp_in.hit            = hit_ff;
      rsp_in.miss           = !hit_ff;
      rsp_in.evicted        = evict_ff;
      rsp_in.modify_hit     = modify_ff;
      rsp_in.way_used       = way_wide[2:0];
      rsp_in.set_index      = set_wide[7:0];
      rsp_in.hits_total     = hit_cnt_in;
      rsp_in.misses_total   = miss_cnt_in;
      rsp_in.evictions_total = evict_cnt_in;
   end

   assign wr_en           = cmd.clear_wr || cmd.commit;
   assign wr_addr         = cmd.clear_wr ? clr_cnt_ff : set_ff;
   assign clr_cnt_in      = clr_cnt_ff + SET_W'(1);
   assign stat.clear_last = &clr_cnt_ff;
   assign rsp_data        = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= SET_BITS_RST;
         ways_ff       <= WAYS_RST;
         block_bits_ff <= BLOCK_BITS_RST;
         clr_cnt_ff    <= '0;
         hit_cnt_ff    <= '0;
         miss_cnt_ff   <= '0;
         evict_cnt_ff  <= '0;
      end else begin
         set_bits_ff   <= set_bits_in;
         ways_ff       <= ways_in;
         block_bits_ff <= block_bits_in;
         if (cmd.clear_wr) clr_cnt_ff <= clr_cnt_in;
         if (cmd.commit) begin
            hit_cnt_ff   <= hit_cnt_in;
            miss_cnt_ff  <= miss_cnt_in;
            evict_cnt_ff <= evict_cnt_in;
         end
      end
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         valid_mem[wr_addr] <= cmd.clear_wr ? '0 : new_valid;
         tag_mem[wr_addr]   <= cmd.clear_wr ? '0 : new_tag;
         age_mem[wr_addr]   <= cmd.clear_wr ? '0 : new_age;
      end
      if (cmd.load_req) begin
         rd_valid_ff <= valid_mem[set_dec];
         rd_tag_ff   <= tag_mem[set_dec];
         rd_age_ff   <= age_mem[set_dec];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         set_ff    <= set_dec;
         tag_ff    <= tag_shift[TAG_W-1:0];
         modify_ff <= (req_data.kind == KIND_MODIFY);
      end
      if (cmd.eval) begin
         hit_ff   <= |match;
         evict_ff <= !(|match) && !(|invalid);
         priority if (|match) begin
            way_ff <= hit_way;
         end else if (|invalid) begin
            way_ff <= inv_way;
         end else begin
            way_ff <= old_way;
         end
      end
      if (cmd.commit) rsp_ff <= rsp_in;
   end

endmodule

### hw/rtl/set_assoc_cache_lru_sim_core.sv
// top level of the tags-only set-associative cache with lru replacement
// response: after the lookup and update states, rsp_valid is registered at commit
// accesses: one at a time, read, evaluated and written back on the per-set tag/age
//    memory; a response still waiting holds the write-back until it drains
// reset: a clearing pass writes every one of the 2**MAX_SET_BITS set rows
//    (256 by default) with req_ready low; csr writes are taken throughout
module set_assoc_cache_lru_sim_core #(
   parameter int MAX_SET_BITS = 8,
   parameter int MAX_WAYS     = 8,
   parameter int ADDRESS_BITS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  sacl_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output sacl_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [sacl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sacl_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sacl_pkg::*;

   ctl_cmd_type cmd;
   dp_stat_type stat;

   sacl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sacl_dp #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS),
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_data  (rsp_data)
   );

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("committed access not presented");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second access taken while one is in flight");

   a_hit_xor_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.hit != rsp_data.miss))
      else $error("hit and miss flags disagree");

   a_evict_on_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.evicted) |-> rsp_data.miss)
      else $error("eviction reported on a hit");

endmodule
